[hw/rtl/flba_pkg.sv]
package flba_pkg;

  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT      = 11'd2047;
  localparam logic [COUNT_W-1:0] NUM_BLOCKS_RESET = 11'd1024;

  localparam logic REG_NUM_BLOCKS = 1'b0;

  typedef struct packed {
    logic [1:0]         operation;
    logic [INDEX_W-1:0] blk_idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] granted_index;
    logic [COUNT_W-1:0] allocated_count;
  } res_t;

endpackage

[hw/rtl/free_list_block_allocator.sv]
// Fixed-size block pool allocator with a LIFO free list of block indexes.
// Command channel: present cmd with start high; a word is taken on a rising
// edge with start high and busy low. Each command gives one result word on
// result, marked by done for exactly one cycle; the receiver cannot stall,
// so a result must be taken in the cycle it is shown.
// Per command, with the next-link memory read registered:
//   free, unknown op, allocate on empty pool: result in the cycle after accept,
//     next command accepted in that same cycle.
//   allocate: the head's link is read at accept, head updates in S_ALLOC;
//     result registered in S_ALLOC, busy until the return to idle.
//   initialize: writes one link per cycle over the whole pool; result once the
//     last link is written, busy meanwhile.
// Configuration: APB pool size register at address 0, written while idle;
// 0 acts as 1, values above MAX_BLOCKS act as MAX_BLOCKS.
// Reset: pool empty (head null), count zero, pool size 1024. The link
// memory is not cleared; run initialize before the first allocate.
module free_list_block_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  flba_pkg::cmd_t   cmd,
  output logic             done,
  output flba_pkg::res_t   result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW = AW + 1;
  localparam int EW = (LW > flba_pkg::COUNT_W) ? LW : flba_pkg::COUNT_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_INIT  = 2'd2;

  logic [1:0]                   state;
  logic [LW-1:0]                head;
  logic [flba_pkg::COUNT_W-1:0] used;
  logic [flba_pkg::COUNT_W-1:0] used_inc;
  logic [flba_pkg::COUNT_W-1:0] used_dec;
  logic [AW-1:0]                walk;
  logic [LW-1:0]                eff_count;
  logic                         walk_last;
  logic                         free_ok;

  logic [LW-1:0] link_mem [MAX_BLOCKS];
  logic [LW-1:0] rd_data;
  logic          we;
  logic [AW-1:0] wa;
  logic [LW-1:0] wd;

  flba_cfg #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .LW(LW)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .eff_count(eff_count)
  );

  assign busy      = (state != S_IDLE);
  assign used_inc  = (used < flba_pkg::COUNT_LIMIT) ? used + 1'b1 : used;
  assign used_dec  = (used != '0) ? used - 1'b1 : used;
  assign walk_last = (LW'(walk) + LW'(1)) == eff_count;
  assign free_ok   = EW'(cmd.blk_idx) < EW'(eff_count);

  always_comb begin
    we = 1'b0;
    wa = walk;
    wd = walk_last ? NULL_LINK : LW'(walk) + LW'(1);
    if (state == S_INIT) begin
      we = 1'b1;
    end else if (state == S_IDLE && start && cmd.operation == flba_pkg::OP_FREE && free_ok) begin
      we = 1'b1;
      wa = AW'(cmd.blk_idx);
      wd = head;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[wa] <= wd;
    end
    rd_data <= link_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NULL_LINK;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.operation)
              flba_pkg::OP_INIT: begin
                state <= S_INIT;
                walk  <= '0;
              end
              flba_pkg::OP_ALLOC: begin
                if (head == NULL_LINK) begin
                  done   <= 1'b1;
                  result <= '{flba_pkg::ST_EMPTY, '0, used};
                end else begin
                  state <= S_ALLOC;
                end
              end
              flba_pkg::OP_FREE: begin
                done <= 1'b1;
                if (free_ok) begin
                  head   <= LW'(cmd.blk_idx);
                  used   <= used_dec;
                  result <= '{flba_pkg::ST_OK, '0, used_dec};
                end else begin
                  result <= '{flba_pkg::ST_RANGE, '0, used};
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{flba_pkg::ST_OK, '0, used};
              end
            endcase
          end
        end
        S_ALLOC: begin
          head   <= rd_data;
          used   <= used_inc;
          done   <= 1'b1;
          result <= '{flba_pkg::ST_OK, flba_pkg::INDEX_W'(head), used_inc};
          state  <= S_IDLE;
        end
        S_INIT: begin
          walk <= walk + 1'b1;
          if (walk_last) begin
            head   <= '0;
            used   <= '0;
            done   <= 1'b1;
            result <= '{flba_pkg::ST_OK, '0, '0};
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == flba_pkg::OP_ALLOC && head != NULL_LINK |=> busy)
    else $error("allocate on nonempty pool did not hold busy");

  a_alloc_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |=> done && result.status == flba_pkg::ST_OK)
    else $error("allocate gave no ok result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == flba_pkg::ST_EMPTY |-> result.granted_index == '0)
    else $error("empty allocate granted an index");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    state != S_ALLOC |-> head <= NULL_LINK)
    else $error("head beyond pool");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> state != S_ALLOC)
    else $error("result shown while allocate pending");

endmodule

[hw/rtl/flba_cfg.sv]
module flba_cfg #(
  parameter int MAX_BLOCKS = 1024,
  parameter int LW = $clog2(MAX_BLOCKS) + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output logic [LW-1:0] eff_count
);

  localparam int EW = (LW > flba_pkg::COUNT_W) ? LW : flba_pkg::COUNT_W;

  logic [flba_pkg::COUNT_W-1:0] num_blocks;
  logic [EW-1:0]                bc_ext;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks <= flba_pkg::NUM_BLOCKS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == flba_pkg::REG_NUM_BLOCKS) begin
      num_blocks <= pwdata[flba_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == flba_pkg::REG_NUM_BLOCKS) begin
      prdata = 32'(num_blocks);
    end else begin
      prdata = 32'd0;
    end
  end

  // clamp to 1..MAX_BLOCKS
  assign bc_ext = EW'(num_blocks);

  always_comb begin
    if (num_blocks == '0) begin
      eff_count = LW'(1);
    end else if (bc_ext > EW'(MAX_BLOCKS)) begin
      eff_count = LW'(MAX_BLOCKS);
    end else begin
      eff_count = LW'(bc_ext);
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_BLOCKS = 1024;
  localparam logic [flba_pkg::COUNT_W-1:0] NULL_LINK = 11'd1024;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int PHASES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  flba_pkg::cmd_t cmd = '0;
  logic busy;
  logic done;
  flba_pkg::res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [flba_pkg::COUNT_W-1:0] link_mem [MAX_BLOCKS];
  logic [flba_pkg::COUNT_W-1:0] head_blk = NULL_LINK;
  logic [flba_pkg::COUNT_W-1:0] used_cnt = '0;
  logic [flba_pkg::COUNT_W-1:0] num_blocks_reg = flba_pkg::NUM_BLOCKS_RESET;
  int held_blocks[$];
  flba_pkg::res_t owed_results[$];
  flba_pkg::res_t owed_word;
  int fail_count = 0;
  int idle_cycles = 0;

  free_list_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int pool_size();
    if (num_blocks_reg == 0) return 1;
    if (num_blocks_reg > NULL_LINK) return MAX_BLOCKS;
    return int'(num_blocks_reg);
  endfunction

  function automatic flba_pkg::res_t apply_pool_op(input flba_pkg::cmd_t c);
    flba_pkg::res_t r;
    int n;
    r = '0;
    r.status = flba_pkg::ST_OK;
    n = pool_size();
    case (c.operation)
      flba_pkg::OP_INIT: begin
        for (int i = 0; i < n - 1; i++) link_mem[i] = flba_pkg::COUNT_W'(i + 1);
        link_mem[n - 1] = NULL_LINK;
        head_blk = '0;
        used_cnt = '0;
        held_blocks.delete();
      end
      flba_pkg::OP_ALLOC: begin
        if (head_blk >= NULL_LINK) begin
          r.status = flba_pkg::ST_EMPTY;
        end else begin
          r.granted_index = head_blk[flba_pkg::INDEX_W-1:0];
          held_blocks.push_back(int'(head_blk));
          head_blk = link_mem[head_blk[flba_pkg::INDEX_W-1:0]];
          if (used_cnt < flba_pkg::COUNT_LIMIT) used_cnt = used_cnt + 1'b1;
        end
      end
      flba_pkg::OP_FREE: begin
        if (int'(c.blk_idx) >= n) begin
          r.status = flba_pkg::ST_RANGE;
        end else begin
          link_mem[c.blk_idx] = head_blk;
          head_blk = {1'b0, c.blk_idx};
          if (used_cnt != 0) used_cnt = used_cnt - 1'b1;
        end
      end
      default: ;
    endcase
    r.allocated_count = used_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $error("result word with none expected: %p", result);
        fail_count++;
      end else begin
        owed_word = owed_results.pop_front();
        if (result.status !== owed_word.status) begin
          $error("status: expected %0d, actual %0d", owed_word.status, result.status);
          fail_count++;
        end
        if (result.granted_index !== owed_word.granted_index) begin
          $error("granted_index: expected %0d, actual %0d",
                 owed_word.granted_index, result.granted_index);
          fail_count++;
        end
        if (result.allocated_count !== owed_word.allocated_count) begin
          $error("allocated_count: expected %0d, actual %0d",
                 owed_word.allocated_count, result.allocated_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [flba_pkg::INDEX_W-1:0] idx,
                         input int gap);
    flba_pkg::cmd_t c;
    c.operation = op;
    c.blk_idx = idx;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    owed_results.push_back(apply_pool_op(c));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_num_blocks(input logic [flba_pkg::COUNT_W-1:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {flba_pkg::REG_NUM_BLOCKS, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    num_blocks_reg = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(value)) begin
      $error("num_blocks readback: expected %0d, actual %0d", value, readback);
      fail_count++;
    end
  endtask

  function automatic flba_pkg::cmd_t pick_cmd();
    flba_pkg::cmd_t c;
    int r;
    int k;
    int pos;
    c.blk_idx = flba_pkg::INDEX_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      c.operation = flba_pkg::OP_INIT;
    end else if (r < 50) begin
      c.operation = flba_pkg::OP_ALLOC;
    end else if (r < 93) begin
      c.operation = flba_pkg::OP_FREE;
      k = $urandom_range(0, 99);
      if (k < 70 && held_blocks.size() > 0) begin
        pos = $urandom_range(0, held_blocks.size() - 1);
        c.blk_idx = flba_pkg::INDEX_W'(held_blocks[pos]);
        held_blocks.delete(pos);
      end else if (k < 85) begin
        c.blk_idx = flba_pkg::INDEX_W'($urandom_range(0, pool_size() - 1));
      end
    end else begin
      c.operation = OP_NONE;
    end
    return c;
  endfunction

  task automatic test_reset_state();
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(flba_pkg::OP_FREE, 10'd1023, $urandom_range(0, 8));
    send_op(flba_pkg::OP_ALLOC, 10'h3FF, $urandom_range(0, 8));
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(OP_NONE, 10'h2AA, $urandom_range(0, 8));
    drain();
  endtask

  task automatic test_register_access();
    set_num_blocks(11'd1);
    set_num_blocks(11'd2047);
    set_num_blocks(11'd0);
    set_num_blocks(11'h555);
    set_num_blocks(11'h2AA);
    set_num_blocks(11'd1024);
  endtask

  task automatic test_directed_ops();
    set_num_blocks(11'd4);
    send_op(flba_pkg::OP_INIT, 10'h155, 0);
    repeat (4) send_op(flba_pkg::OP_ALLOC, 10'd0, $urandom_range(0, 2));
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(flba_pkg::OP_FREE, 10'd4, 0);
    send_op(flba_pkg::OP_FREE, 10'd1023, $urandom_range(0, 8));
    send_op(flba_pkg::OP_FREE, 10'd3, 0);
    send_op(flba_pkg::OP_FREE, 10'd0, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, $urandom_range(0, 8));
    send_op(flba_pkg::OP_FREE, 10'd2, 0);
    send_op(flba_pkg::OP_FREE, 10'd2, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(OP_NONE, 10'h3FF, 0);
    drain();
    set_num_blocks(11'd0);
    send_op(flba_pkg::OP_INIT, 10'd0, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    send_op(flba_pkg::OP_FREE, 10'd1, 0);
    send_op(flba_pkg::OP_FREE, 10'd0, 0);
    drain();
    set_num_blocks(11'd2047);
    send_op(flba_pkg::OP_INIT, 10'd0, 0);
    send_op(flba_pkg::OP_FREE, 10'd1023, 0);
    send_op(flba_pkg::OP_ALLOC, 10'd0, 0);
    drain();
  endtask

  task automatic test_double_free_loop();
    set_num_blocks(11'd1);
    send_op(flba_pkg::OP_INIT, 10'd0, 0);
    send_op(flba_pkg::OP_FREE, 10'd0, 0);
    repeat (32) send_op(flba_pkg::OP_ALLOC, flba_pkg::INDEX_W'($urandom), 0);
    send_op(flba_pkg::OP_INIT, 10'd0, 0);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [flba_pkg::COUNT_W-1:0] counts [PHASES];
    int per_phase;
    bit burst;
    flba_pkg::cmd_t c;
    counts = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd0, 11'd1024, 11'd2047,
               11'd0, 11'd0};
    counts[8] = flba_pkg::COUNT_W'($urandom_range(1, 64));
    counts[9] = flba_pkg::COUNT_W'($urandom_range(1, 1024));
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_num_blocks(counts[p]);
      burst = (p % 3 == 0);
      send_op(flba_pkg::OP_INIT, flba_pkg::INDEX_W'($urandom), 0);
      for (int i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2) drain();
        c = pick_cmd();
        send_op(c.operation, c.blk_idx, burst ? 0 : $urandom_range(0, 8));
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_register_access();
    test_directed_ops();
    test_double_free_loop();
    test_random_traffic();
    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
